// ===== rtl/spf_pkg.sv =====
// Shared types and constants for the slot pool with ordered release queue.
package spf_pkg;

  // Request opcodes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // Fixed field widths of the request and result channels
  localparam int ID_W       = 8;
  localparam int WORD_W     = 64;
  localparam int SLOT_OUT_W = 3;
  localparam int CNT_OUT_W  = 4;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic push_start;    // write record and ring entry, read free-list link
    logic pop_start;     // read oldest ring entry
    logic pop_fetch;     // read record of the popped slot
    logic push_commit;   // update pointers and load push result
    logic pop_commit;    // relink slot, update pointers, load pop result
    logic drop_commit;   // load dropped-push result
    logic empty_commit;  // load empty-pop result
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic pool_full;     // no free slot
    logic ring_empty;    // no queued record
    logic out_free;      // result register can take a new result this cycle
  } dp_status_t;

endpackage

// ===== rtl/spf_ctrl.sv =====
// Sequencing controller: accepts requests and steps the datapath through each one.
module spf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_opcode,
  output logic                in_stall,
  input  spf_pkg::dp_status_t status,
  output spf_pkg::dp_cmd_t    cmd
);
  import spf_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_PUSH   = 6'b000010,
    S_POP_RD = 6'b000100,
    S_POP_WR = 6'b001000,
    S_DROP   = 6'b010000,
    S_EMPTY  = 6'b100000
  } ctl_state_t;

  ctl_state_t state_r, state_nxt;
  logic       accept;

  // New requests only while idle
  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && (state_r == S_IDLE);

  // Next state and command decode
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_opcode == OP_PUSH) begin
            if (status.pool_full) begin
              state_nxt = S_DROP;
            end else begin
              cmd.push_start = 1'b1;
              state_nxt      = S_PUSH;
            end
          end else begin
            if (status.ring_empty) begin
              state_nxt = S_EMPTY;
            end else begin
              cmd.pop_start = 1'b1;
              state_nxt     = S_POP_RD;
            end
          end
        end
      end
      S_PUSH: begin
        if (status.out_free) begin
          cmd.push_commit = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      S_POP_RD: begin
        cmd.pop_fetch = 1'b1;
        state_nxt     = S_POP_WR;
      end
      S_POP_WR: begin
        if (status.out_free) begin
          cmd.pop_commit = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_DROP: begin
        if (status.out_free) begin
          cmd.drop_commit = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      S_EMPTY: begin
        if (status.out_free) begin
          cmd.empty_commit = 1'b1;
          state_nxt        = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/spf_datapath.sv =====
// Datapath: record store, free list, slot ring, counters and result register.
module spf_datapath #(
  parameter int POOL_SLOTS = 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  spf_pkg::dp_cmd_t                     cmd,
  output spf_pkg::dp_status_t                  status,
  input  logic [spf_pkg::ID_W-1:0]             in_sensor_id,
  input  logic [spf_pkg::WORD_W-1:0]           in_value_bits,
  input  logic [spf_pkg::WORD_W-1:0]           in_timestamp_bits,
  input  logic                                 out_stall,
  output logic                                 out_valid,
  output logic                                 out_push_accepted,
  output logic                                 out_push_dropped,
  output logic                                 out_pop_valid,
  output logic [spf_pkg::SLOT_OUT_W-1:0]       out_slot_number,
  output logic [spf_pkg::ID_W-1:0]             out_sensor_id_out,
  output logic [spf_pkg::WORD_W-1:0]           out_value_out,
  output logic [spf_pkg::WORD_W-1:0]           out_timestamp_out,
  output logic [spf_pkg::CNT_OUT_W-1:0]        out_used_cnt,
  output logic [spf_pkg::CNT_OUT_W-1:0]        out_free_slots,
  output logic                                 out_queue_empty
);
  import spf_pkg::*;

  localparam int IW  = $clog2(POOL_SLOTS);        // slot index width
  localparam int CW  = $clog2(POOL_SLOTS + 1);    // count width, also holds "none"
  localparam int SXW = (IW > SLOT_OUT_W) ? IW : SLOT_OUT_W;
  localparam int CXW = (CW > CNT_OUT_W) ? CW : CNT_OUT_W;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [WORD_W-1:0] val;
    logic [WORD_W-1:0] ts;
  } rec_t;

  // Memories
  rec_t            rec_mem  [POOL_SLOTS];
  logic [IW-1:0]   ring_mem [POOL_SLOTS];
  logic [CW-1:0]   fn_mem   [POOL_SLOTS];
  logic [POOL_SLOTS-1:0] fn_vld_r;

  // Registered read data
  rec_t            rec_rdata_r;
  logic [IW-1:0]   ring_rdata_r;
  logic [CW-1:0]   fn_rdata_r;
  logic            fn_rvld_r;
  logic [IW-1:0]   fn_ridx_r;

  // Control state
  logic [CW-1:0]   free_head_r,  free_head_nxt;
  logic [CW-1:0]   free_total_r, free_total_nxt;
  logic [IW-1:0]   rd_ptr_r,     rd_ptr_nxt;
  logic [IW-1:0]   wr_ptr_r,     wr_ptr_nxt;
  logic [CW-1:0]   ring_count_r, ring_count_nxt;
  logic            out_valid_r,  out_valid_nxt;

  logic [IW-1:0]   head_idx;
  logic [CW-1:0]   fn_link;
  logic            commit;
  logic [IW-1:0]   slot_sel;
  logic [SXW-1:0]  slot_wide;
  logic [CXW-1:0]  used_wide;
  logic [CXW-1:0]  free_wide;

  assign head_idx = free_head_r[IW-1:0];
  assign commit   = cmd.push_commit | cmd.pop_commit | cmd.drop_commit | cmd.empty_commit;

  // An entry never written is read as its reset link, slot + 1
  assign fn_link = fn_rvld_r ? fn_rdata_r : (CW'(fn_ridx_r) + CW'(1));

  assign status.pool_full  = (free_total_r == '0);
  assign status.ring_empty = (ring_count_r == '0);
  assign status.out_free   = !out_valid_r || !out_stall;
  assign out_valid         = out_valid_r;

  // Record store: written on push, read on pop
  always_ff @(posedge clk) begin
    if (cmd.push_start) begin
      rec_mem[head_idx] <= '{id: in_sensor_id, val: in_value_bits, ts: in_timestamp_bits};
    end
    if (cmd.pop_fetch) begin
      rec_rdata_r <= rec_mem[ring_rdata_r];
    end
  end

  // Slot ring: written on push, read on pop
  always_ff @(posedge clk) begin
    if (cmd.push_start) begin
      ring_mem[wr_ptr_r] <= head_idx;
    end
    if (cmd.pop_start) begin
      ring_rdata_r <= ring_mem[rd_ptr_r];
    end
  end

  // Free-list links: read on push, written when a slot is released
  always_ff @(posedge clk) begin
    if (cmd.pop_commit) begin
      fn_mem[ring_rdata_r] <= free_head_r;
    end
    if (cmd.push_start) begin
      fn_rdata_r <= fn_mem[head_idx];
      fn_rvld_r  <= fn_vld_r[head_idx];
      fn_ridx_r  <= head_idx;
    end
  end

  // Link valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fn_vld_r <= '0;
    end else if (cmd.pop_commit) begin
      fn_vld_r[ring_rdata_r] <= 1'b1;
    end
  end

  // Pointer and counter updates
  always_comb begin
    free_head_nxt  = free_head_r;
    free_total_nxt = free_total_r;
    rd_ptr_nxt     = rd_ptr_r;
    wr_ptr_nxt     = wr_ptr_r;
    ring_count_nxt = ring_count_r;
    if (cmd.push_commit) begin
      free_head_nxt  = fn_link;
      free_total_nxt = free_total_r - CW'(1);
      wr_ptr_nxt     = (wr_ptr_r == IW'(POOL_SLOTS - 1)) ? '0 : wr_ptr_r + IW'(1);
      ring_count_nxt = ring_count_r + CW'(1);
    end
    if (cmd.pop_commit) begin
      free_head_nxt  = CW'(ring_rdata_r);
      free_total_nxt = free_total_r + CW'(1);
      rd_ptr_nxt     = (rd_ptr_r == IW'(POOL_SLOTS - 1)) ? '0 : rd_ptr_r + IW'(1);
      ring_count_nxt = ring_count_r - CW'(1);
    end
  end

  // Result register handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_head_r  <= '0;
      free_total_r <= CW'(POOL_SLOTS);
      rd_ptr_r     <= '0;
      wr_ptr_r     <= '0;
      ring_count_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      free_head_r  <= free_head_nxt;
      free_total_r <= free_total_nxt;
      rd_ptr_r     <= rd_ptr_nxt;
      wr_ptr_r     <= wr_ptr_nxt;
      ring_count_r <= ring_count_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Result fields, counts as they stand after this request
  always_comb begin
    slot_sel = '0;
    if (cmd.push_commit) begin
      slot_sel = head_idx;
    end else if (cmd.pop_commit) begin
      slot_sel = ring_rdata_r;
    end
  end

  assign slot_wide = SXW'(slot_sel);
  assign used_wide = CXW'(CW'(POOL_SLOTS) - free_total_nxt);
  assign free_wide = CXW'(free_total_nxt);

  always_ff @(posedge clk) begin
    if (commit) begin
      out_push_accepted <= cmd.push_commit;
      out_push_dropped  <= cmd.drop_commit;
      out_pop_valid     <= cmd.pop_commit;
      out_slot_number   <= slot_wide[SLOT_OUT_W-1:0];
      out_sensor_id_out <= cmd.pop_commit ? rec_rdata_r.id  : '0;
      out_value_out     <= cmd.pop_commit ? rec_rdata_r.val : '0;
      out_timestamp_out <= cmd.pop_commit ? rec_rdata_r.ts  : '0;
      out_used_cnt      <= used_wide[CNT_OUT_W-1:0];
      out_free_slots    <= free_wide[CNT_OUT_W-1:0];
      out_queue_empty   <= (ring_count_nxt == '0);
    end
  end

endmodule

// ===== rtl/slot_pool_fifo_pipeline.sv =====
// Top level: slot pool allocator with an in-order release queue.
//
// Request channel (in_*): in_opcode selects push (store a record in a free slot
// and queue it) or pop (return the oldest queued record and free its slot).
// A request is taken at a clock edge with in_valid high and in_stall low.
// Result channel (out_*): exactly one result per request, in request order,
// taken at an edge with out_valid high and out_stall low.
// A push, a dropped push or a pop on an empty queue loads its result from its
// controller state (S_PUSH, S_DROP or S_EMPTY); a pop first passes S_POP_RD
// and then loads from S_POP_WR, as set by the two chained registered memory
// reads (slot ring, then record store). One request is worked on at a time:
// a new request is taken only once the last has loaded its result.
// The result register decouples the sides: the next request is taken while a
// result waits; a stalled receiver holds the result steady and the block
// finishes the next request up to the point of loading its result, then waits.
// Reset (synchronous, rst_n low) empties the queue, returns every slot to the
// free list in ascending order and clears out_valid; no clearing pass is needed.
module slot_pool_fifo_pipeline #(
  parameter int POOL_SLOTS = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_opcode,
  input  logic [spf_pkg::ID_W-1:0]       in_sensor_id,
  input  logic [spf_pkg::WORD_W-1:0]     in_value_bits,
  input  logic [spf_pkg::WORD_W-1:0]     in_timestamp_bits,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_push_accepted,
  output logic                           out_push_dropped,
  output logic                           out_pop_valid,
  output logic [spf_pkg::SLOT_OUT_W-1:0] out_slot_number,
  output logic [spf_pkg::ID_W-1:0]       out_sensor_id_out,
  output logic [spf_pkg::WORD_W-1:0]     out_value_out,
  output logic [spf_pkg::WORD_W-1:0]     out_timestamp_out,
  output logic [spf_pkg::CNT_OUT_W-1:0]  out_used_cnt,
  output logic [spf_pkg::CNT_OUT_W-1:0]  out_free_slots,
  output logic                           out_queue_empty
);
  import spf_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Request sequencing
  spf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_stall  (in_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Storage, pointers and result register
  spf_datapath #(
    .POOL_SLOTS (POOL_SLOTS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .in_sensor_id      (in_sensor_id),
    .in_value_bits     (in_value_bits),
    .in_timestamp_bits (in_timestamp_bits),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_push_accepted (out_push_accepted),
    .out_push_dropped  (out_push_dropped),
    .out_pop_valid     (out_pop_valid),
    .out_slot_number   (out_slot_number),
    .out_sensor_id_out (out_sensor_id_out),
    .out_value_out     (out_value_out),
    .out_timestamp_out (out_timestamp_out),
    .out_used_cnt      (out_used_cnt),
    .out_free_slots    (out_free_slots),
    .out_queue_empty   (out_queue_empty)
  );

endmodule

// ===== rtl/spf_checker.sv =====
// Port-level checker for the slot pool and its bind to the top level.
module spf_checker #(
  parameter int POOL_SLOTS = 8
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic                           out_push_accepted,
  input logic                           out_push_dropped,
  input logic                           out_pop_valid,
  input logic [spf_pkg::SLOT_OUT_W-1:0] out_slot_number,
  input logic [spf_pkg::CNT_OUT_W-1:0]  out_used_cnt,
  input logic [spf_pkg::CNT_OUT_W-1:0]  out_free_slots,
  input logic                           out_queue_empty
);
  import spf_pkg::*;

  localparam logic [CNT_OUT_W-1:0] POOL_LOW = CNT_OUT_W'(POOL_SLOTS);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_slot_number) &&
    $stable(out_used_cnt) && $stable(out_free_slots))
    else $error("result changed while stalled");

  // At most one outcome flag per result
  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot0({out_push_accepted, out_push_dropped, out_pop_valid}))
    else $error("more than one outcome flag set");

  // Every slot is either queued or free
  a_conserve: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (CNT_OUT_W'(out_used_cnt + out_free_slots) == POOL_LOW))
    else $error("used and free counts do not cover the pool");

  // A queued push leaves the queue non-empty
  a_push_queued: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_push_accepted |-> !out_queue_empty)
    else $error("accepted push reported empty queue");

  // A push is dropped only when nothing is free
  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_push_dropped |-> (out_free_slots == '0))
    else $error("push dropped with free slots left");

endmodule

bind slot_pool_fifo_pipeline spf_checker #(
  .POOL_SLOTS (POOL_SLOTS)
) u_spf_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_push_accepted (out_push_accepted),
  .out_push_dropped  (out_push_dropped),
  .out_pop_valid     (out_pop_valid),
  .out_slot_number   (out_slot_number),
  .out_used_cnt      (out_used_cnt),
  .out_free_slots    (out_free_slots),
  .out_queue_empty   (out_queue_empty)
);
